// ===== rtl/ffa_pkg.sv =====
// Shared types, constants and helpers for the flipbook frame animator.
`timescale 1ns / 1ps

package ffa_pkg;

	// Particle store geometry (power of two, slot is the low index bits)
	localparam int PARTICLE_COUNT = 1024;
	localparam int SLOT_W         = $clog2(PARTICLE_COUNT);

	// Field widths
	localparam int FRAME_W = 24;
	localparam int TOTAL_W = 13;
	localparam int DIM_W   = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// Item modes
	localparam logic [1:0] MODE_ADVANCE = 2'd0;
	localparam logic [1:0] MODE_SPAWN   = 2'd1;
	localparam logic [1:0] MODE_QUERY   = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TILE_COLUMNS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_ROWS       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_SEC  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_MODE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_FRACTION  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_START_FRACTION2 = 3'd5;

	// Divider step counts for each pass
	localparam logic [4:0] WRAP_STEPS = 5'd13;
	localparam logic [4:0] ROW_STEPS  = 5'd12;
	localparam logic [4:0] FRAC_STEPS = 5'd16;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_MUL4,
		S_FRAME,
		S_WRAP,
		S_WRAP_END,
		S_TILE,
		S_ROW,
		S_ULOAD,
		S_UDIV,
		S_VLOAD,
		S_VDIV,
		S_EMIT
	} ffa_state_t;

	// Sheet dimension clamped to 1..64
	function automatic logic [DIM_W-1:0] sheet_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = 7'd1;
		end else if (v > 7'd64) begin
			r = 7'd64;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== rtl/flipbook_frame_animator_top.sv =====
// Flipbook frame animator: per-particle frame store, sequencer, shared multiplier and divider.
`timescale 1ns / 1ps

// One item at a time. After acceptance a small sequencer runs one 32x17
// multiplier and one restoring divider (one quotient bit per cycle) over the
// item. An advance uses 13 divider steps for the modulo wrap, 12 for the tile
// row/column split and 16 each for the U and V offsets. The sequencer
// returns to idle after each result load before it takes the next item.
// in_ready is high only while the sequencer is idle; the result sits in an
// output register, so the next item is taken while it still waits. Config
// writes are always taken (cfg_ready is tied high) and must only be issued
// while no item is in flight. The frame store holds no reset value: query or
// advance a particle only after it was spawned.
module flipbook_frame_animator_top
	import ffa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// item input
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            mode,
	input  logic [9:0]            particle_index,
	input  logic [19:0]           delta_time,
	input  logic [15:0]           random_scale,
	// result output
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [9:0]            particle_slot,
	output logic [FRAME_W-1:0]    current_frame,
	output logic [15:0]           u_offset,
	output logic [15:0]           v_offset
);

	ffa_state_t state_q, state_d;

	// configuration registers
	logic [DIM_W-1:0]   cols_cfg_q, rows_cfg_q;
	logic [15:0]        fps_q, sf_q, sf2_q;
	logic               sm_q;
	logic [DIM_W-1:0]   cols_c, rows_c;
	logic [TOTAL_W-1:0] total_q;
	logic [2*DIM_W-1:0] total_d;

	// item registers
	logic [1:0]         mode_q;
	logic [9:0]         pidx_q;
	logic [19:0]        dt_q;
	logic [15:0]        rs_q;
	logic [FRAME_W-1:0] rd_q, frame_q;
	logic [11:0]        low_q;
	logic [5:0]         row_q;
	logic [15:0]        u_q;

	// frame store
	logic [FRAME_W-1:0] mem [PARTICLE_COUNT];

	// shared multiplier
	logic [31:0] mul_a, acc_q;
	logic [16:0] mul_b;
	logic [48:0] prod_d, prod_q;

	// shared divider
	logic [12:0] rem_q, dsr_q;
	logic [15:0] dvd_q;
	logic [4:0]  cnt_q;
	logic [13:0] shift_d;
	logic [14:0] diff_d;
	logic        ge_d;
	logic        div_step;
	logic        div_last;

	// misc datapath
	logic [24:0] sum_d;
	logic [11:0] total_m1, tile_d;
	logic        store_we, out_load;

	// output register
	logic               out_valid_q;
	logic [9:0]         slot_q;
	logic [FRAME_W-1:0] cur_q;
	logic [15:0]        uo_q, vo_q;

	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign particle_slot = slot_q;
	assign current_frame = cur_q;
	assign u_offset      = uo_q;
	assign v_offset      = vo_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_cfg_q <= 7'd1;
			rows_cfg_q <= 7'd1;
			fps_q      <= '0;
			sm_q       <= 1'b0;
			sf_q       <= '0;
			sf2_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TILE_COLUMNS:    cols_cfg_q <= cfg_data[DIM_W-1:0];
				REG_TILE_ROWS:       rows_cfg_q <= cfg_data[DIM_W-1:0];
				REG_FRAMES_PER_SEC:  fps_q      <= cfg_data;
				REG_START_MODE:      sm_q       <= cfg_data[0];
				REG_START_FRACTION:  sf_q       <= cfg_data;
				REG_START_FRACTION2: sf2_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamped sheet size and frame count
	assign cols_c  = sheet_dim(cols_cfg_q);
	assign rows_c  = sheet_dim(rows_cfg_q);
	assign total_d = cols_c * rows_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= 13'd1;
		end else begin
			total_q <= total_d[TOTAL_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:     if (in_valid) state_d = S_MUL1;
			S_MUL1:     state_d = (mode_q == MODE_SPAWN && sm_q) ? S_MUL2 : S_FRAME;
			S_MUL2:     state_d = S_MUL3;
			S_MUL3:     state_d = S_MUL4;
			S_MUL4:     state_d = S_FRAME;
			S_FRAME:    state_d = (mode_q == MODE_ADVANCE) ? S_WRAP : S_TILE;
			S_WRAP:     if (div_last) state_d = S_WRAP_END;
			S_WRAP_END: state_d = S_TILE;
			S_TILE:     state_d = S_ROW;
			S_ROW:      if (div_last) state_d = S_ULOAD;
			S_ULOAD:    state_d = S_UDIV;
			S_UDIV:     if (div_last) state_d = S_VLOAD;
			S_VLOAD:    state_d = S_VDIV;
			S_VDIV:     if (div_last) state_d = S_EMIT;
			S_EMIT:     if (!out_valid_q || out_ready) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		div_step = 1'b0;
		store_we = 1'b0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_MUL1: begin
				if (mode_q == MODE_ADVANCE) begin
					mul_a = {12'b0, dt_q};
					mul_b = {1'b0, fps_q};
				end else if (sm_q) begin
					mul_a = {16'b0, sf_q};
					mul_b = 17'h10000 - {1'b0, rs_q};
				end else begin
					mul_a = {16'b0, sf_q};
					mul_b = {4'b0, total_q};
				end
			end
			S_MUL2: begin
				mul_a = {16'b0, sf2_q};
				mul_b = {1'b0, rs_q};
			end
			S_MUL4: begin
				mul_a = acc_q;
				mul_b = {4'b0, total_q};
			end
			S_WRAP, S_ROW, S_UDIV, S_VDIV: div_step = 1'b1;
			S_TILE: store_we = (mode_q == MODE_ADVANCE) || (mode_q == MODE_SPAWN);
			S_EMIT: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// shared multiplier, registered product
	assign prod_d = {17'b0, mul_a} * {32'b0, mul_b};

	// shared restoring divider step
	assign shift_d  = {rem_q, dvd_q[15]};
	assign diff_d   = {1'b0, shift_d} - {2'b0, dsr_q};
	assign ge_d     = ~diff_d[14];
	assign div_last = div_step && (cnt_q == 5'd1);

	// advance sum and clamped tile
	assign sum_d    = {1'b0, rd_q} + {1'b0, prod_q[35:12]};
	assign total_m1 = 12'(total_q - 13'd1);
	assign tile_d   = (frame_q[23:12] > total_m1) ? total_m1 : frame_q[23:12];

	// frame store: read on accept, write back after the frame is final
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rd_q <= mem[particle_index[SLOT_W-1:0]];
		end
		if (store_we) begin
			mem[pidx_q[SLOT_W-1:0]] <= frame_q;
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q <= mode;
			pidx_q <= particle_index;
			dt_q   <= delta_time;
			rs_q   <= random_scale;
		end
		prod_q <= prod_d;
		if (div_step) begin
			rem_q <= ge_d ? diff_d[12:0] : shift_d[12:0];
			dvd_q <= {dvd_q[14:0], ge_d};
			cnt_q <= cnt_q - 5'd1;
		end
		case (state_q)
			S_MUL2: acc_q <= prod_q[31:0];
			S_MUL3: acc_q <= acc_q + prod_q[31:0];
			S_FRAME: begin
				if (mode_q == MODE_ADVANCE) begin
					// wrap: (sum >> 12) mod total, fraction bits pass through
					low_q <= sum_d[11:0];
					rem_q <= '0;
					dvd_q <= {sum_d[24:12], 3'b0};
					dsr_q <= total_q;
					cnt_q <= WRAP_STEPS;
				end else if (mode_q == MODE_SPAWN) begin
					frame_q <= sm_q ? prod_q[43:20] : prod_q[27:4];
				end else begin
					frame_q <= rd_q;
				end
			end
			S_WRAP_END: frame_q <= {rem_q[11:0], low_q};
			S_TILE: begin
				// tile / columns: quotient is the row, remainder the column
				rem_q <= '0;
				dvd_q <= {tile_d, 4'b0};
				dsr_q <= {6'b0, cols_c};
				cnt_q <= ROW_STEPS;
			end
			S_ULOAD: begin
				row_q <= dvd_q[5:0];
				rem_q <= {7'b0, rem_q[5:0]};
				dvd_q <= '0;
				dsr_q <= {6'b0, cols_c};
				cnt_q <= FRAC_STEPS;
			end
			S_VLOAD: begin
				u_q   <= dvd_q;
				rem_q <= {7'b0, row_q};
				dvd_q <= '0;
				dsr_q <= {6'b0, rows_c};
				cnt_q <= FRAC_STEPS;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			slot_q <= pidx_q;
			cur_q  <= frame_q;
			uo_q   <= u_q;
			vo_q   <= dvd_q;
		end
	end

	// a new transaction is never taken while one is in flight
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while sequencer busy");

	// the wrapped frame stays below the frame count
	a_wrap_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TILE && mode_q == MODE_ADVANCE) |-> ({1'b0, frame_q[23:12]} < total_q))
		else $error("wrapped frame not below total");

	// divider never steps with an exhausted count
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		div_step |-> (cnt_q != 5'd0))
		else $error("divider stepped past its count");

	// a result is loaded only from the emit state and is then presented
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid && state_q == S_IDLE))
		else $error("result not presented after load");

endmodule
